// File: hdl/hcd_pkg.sv
// Shared types, constants and character helpers for the chunked body decoder.
package hcd_pkg;

    // Receive buffer depth; sizes on a size line saturate at SIZE_CAP.
    localparam int unsigned BUF_DEPTH = 8192;
    localparam int unsigned SIZE_CAP  = (BUF_DEPTH > 8192) ? BUF_DEPTH : 8192;
    localparam int unsigned SZ_W      = $clog2(SIZE_CAP + 1);

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REST_W = 13;

    // Characters that steer the size line parser.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    typedef logic [1:0] t_cause;
    localparam t_cause CAUSE_RAN_OUT   = 2'd0;
    localparam t_cause CAUSE_ZERO_SIZE = 2'd1;
    localparam t_cause CAUSE_MALFORMED = 2'd2;
    localparam t_cause CAUSE_TOO_LONG  = 2'd3;

    typedef enum logic [11:0] {
        PH_LEAD    = 12'b0000_0000_0001,
        PH_LEAD_CR = 12'b0000_0000_0010,
        PH_SIGNED  = 12'b0000_0000_0100,
        PH_ZERO    = 12'b0000_0000_1000,
        PH_HEX_X   = 12'b0000_0001_0000,
        PH_DIGITS  = 12'b0000_0010_0000,
        PH_TRAIL   = 12'b0000_0100_0000,
        PH_LINE_CR = 12'b0000_1000_0000,
        PH_PAYLOAD = 12'b0001_0000_0000,
        PH_OPT_CR  = 12'b0010_0000_0000,
        PH_OPT_CR2 = 12'b0100_0000_0000,
        PH_STOPPED = 12'b1000_0000_0000
    } t_phase;

    // Hex digit decode: bit 4 set when the byte is a hex digit, low bits its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Whitespace skipped ahead of a size: space, TAB, LF, VT and FF.
    function automatic logic is_lead_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

// File: hdl/http_chunked_decoder_unit.sv
// Top level of the chunked transfer decoder: size line parser and payload forwarder.
//
//  Channel   Dir  Signals                          Contents
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata[7:0] data_byte, [20:8] bytes_after
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata[7:0] payload_byte, tlast
//                                                  buffer_end, tuser[0] has_payload,
//                                                  tuser[2:1] stop_cause
//
// One request is accepted per clock while o_s_axis_tready is high. A request is taken
// into an input register, and in the following cycle the parser step runs between that
// register and the result register. i_rst_n is synchronous and active low; it empties
// both registers and returns the parser to the start of a size line.
// When the result register is full and not taken, a byte that yields a result waits in the
// input register and o_s_axis_tready falls; bytes that yield no result still drain.
module http_chunked_decoder_unit
    import hcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [7:0] data_byte, [20:8] bytes_after, zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]  o_m_axis_tuser,   // [0] has_payload, [2:1] stop_cause
    output logic        o_m_axis_tlast    // buffer_end
);

    localparam logic [SZ_W+3:0] SIZE_CAP_X = (SZ_W + 4)'(SIZE_CAP);

    // Input register.
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [REST_W-1:0]   r_in_rest;

    // Parser state.
    t_phase              r_phase, n_phase;
    logic [SZ_W-1:0]     r_size, n_size;
    logic [SZ_W-1:0]     r_left, n_left;
    logic                r_neg, n_neg;
    t_cause              r_stop, n_stop;

    // Result register.
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_has;
    logic                r_out_last;
    t_cause              r_out_cause;

    logic                emit;
    logic                res_valid;
    logic                buf_end;
    logic                out_free;
    logic                advance;
    logic                do_lead;
    logic                do_first;
    logic                do_digits;
    logic [4:0]          hex;
    logic [SZ_W+3:0]     size_sum;
    logic [SZ_W-1:0]     size_add;
    logic [SZ_W-1:0]     left_dec;
    logic [SZ_W-1:0]     rest_x;
    t_phase              step_phase;
    t_cause              step_stop;

    assign hex      = hex_decode(r_in_byte);
    // Low nibble of the shifted value is zero, so OR adds the digit.
    assign size_sum = {r_size, 4'b0000} | {{SZ_W{1'b0}}, hex[3:0]};
    assign size_add = (size_sum > SIZE_CAP_X) ? SZ_W'(SIZE_CAP) : size_sum[SZ_W-1:0];
    assign left_dec = (r_left != '0) ? (r_left - SZ_W'(1)) : '0;
    assign rest_x   = SZ_W'(r_in_rest);
    assign buf_end  = (r_in_rest == '0);

    // One parser step for the byte in the input register.
    always_comb begin
        step_phase = r_phase;
        n_size     = r_size;
        n_left     = r_left;
        n_neg      = r_neg;
        step_stop  = r_stop;
        emit       = 1'b0;
        do_lead    = 1'b0;
        do_first   = 1'b0;
        do_digits  = 1'b0;

        case (r_phase)
            PH_PAYLOAD: begin
                emit   = 1'b1;
                n_left = left_dec;
                if (left_dec == '0) begin
                    step_phase = PH_OPT_CR;
                end
            end
            PH_STOPPED: begin
            end
            PH_OPT_CR: begin
                if (r_in_byte == CH_CR) begin
                    step_phase = PH_OPT_CR2;
                end else begin
                    do_lead = 1'b1;
                end
            end
            PH_OPT_CR2: begin
                if (r_in_byte == CH_LF) begin
                    step_phase = PH_LEAD;
                end else begin
                    // A lone CR counts as leading whitespace of the next line.
                    do_lead = 1'b1;
                end
            end
            PH_LEAD_CR: begin
                if (r_in_byte == CH_LF) begin
                    // The line ended before any digit.
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_MALFORMED;
                end else begin
                    do_lead = 1'b1;
                end
            end
            PH_LEAD: begin
                do_lead = 1'b1;
            end
            PH_SIGNED: begin
                do_first = 1'b1;
            end
            PH_ZERO: begin
                if (r_in_byte == CH_X_LO || r_in_byte == CH_X_UP) begin
                    step_phase = PH_HEX_X;
                end else begin
                    do_digits = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digits = 1'b1;
            end
            PH_HEX_X: begin
                if (hex[4]) begin
                    n_size     = size_add;
                    step_phase = PH_DIGITS;
                end else begin
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_MALFORMED;
                end
            end
            PH_TRAIL: begin
                if (r_in_byte == CH_SPACE) begin
                    step_phase = PH_TRAIL;
                end else if (r_in_byte == CH_CR) begin
                    step_phase = PH_LINE_CR;
                end else begin
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_MALFORMED;
                end
            end
            PH_LINE_CR: begin
                if (r_in_byte != CH_LF) begin
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_MALFORMED;
                end else if (r_neg && r_size != '0) begin
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_MALFORMED;
                end else if (r_size == '0) begin
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_ZERO_SIZE;
                end else if (r_size > rest_x) begin
                    step_phase = PH_STOPPED;
                    step_stop  = CAUSE_TOO_LONG;
                end else begin
                    n_left     = r_size;
                    step_phase = PH_PAYLOAD;
                    n_size     = '0;
                    n_neg      = 1'b0;
                end
            end
            default: begin
                step_phase = PH_STOPPED;
                step_stop  = CAUSE_MALFORMED;
            end
        endcase

        if (do_lead) begin
            if (is_lead_space(r_in_byte)) begin
                step_phase = PH_LEAD;
            end else if (r_in_byte == CH_CR) begin
                step_phase = PH_LEAD_CR;
            end else if (r_in_byte == CH_PLUS || r_in_byte == CH_MINUS) begin
                n_neg      = (r_in_byte == CH_MINUS);
                step_phase = PH_SIGNED;
            end else begin
                do_first = 1'b1;
            end
        end

        if (do_first) begin
            if (hex[4]) begin
                n_size     = size_add;
                step_phase = (hex[3:0] == 4'd0) ? PH_ZERO : PH_DIGITS;
            end else begin
                step_phase = PH_STOPPED;
                step_stop  = CAUSE_MALFORMED;
            end
        end

        if (do_digits) begin
            if (hex[4]) begin
                n_size     = size_add;
                step_phase = PH_DIGITS;
            end else if (r_in_byte == CH_SPACE) begin
                step_phase = PH_TRAIL;
            end else if (r_in_byte == CH_CR) begin
                step_phase = PH_LINE_CR;
            end else begin
                step_phase = PH_STOPPED;
                step_stop  = CAUSE_MALFORMED;
            end
        end

        // The last byte of a buffer returns the parser to its start.
        n_phase = step_phase;
        n_stop  = step_stop;
        if (buf_end) begin
            n_phase = PH_LEAD;
            n_size  = '0;
            n_left  = '0;
            n_neg   = 1'b0;
            n_stop  = CAUSE_RAN_OUT;
        end
    end

    assign res_valid       = emit || buf_end;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (!res_valid || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata[7:0];
            r_in_rest <= i_s_axis_tdata[20:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_size  <= '0;
            r_left  <= '0;
            r_neg   <= 1'b0;
            r_stop  <= CAUSE_RAN_OUT;
        end else if (advance) begin
            r_phase <= n_phase;
            r_size  <= n_size;
            r_left  <= n_left;
            r_neg   <= n_neg;
            r_stop  <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_byte  <= emit ? r_in_byte : '0;
            r_out_has   <= emit;
            r_out_last  <= buf_end;
            r_out_cause <= (buf_end && step_phase == PH_STOPPED) ? step_stop : CAUSE_RAN_OUT;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = {r_out_cause, r_out_has};
    assign o_m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // A payload in progress always has bytes left to forward.
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    // Decoding only stops with a real cause.
    a_stop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOPPED) |-> (r_stop != CAUSE_RAN_OUT))
        else $error("stopped without a cause");

    // The size accumulator never passes its saturation cap.
    a_size_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SZ_W'(SIZE_CAP))
        else $error("size value above cap");

    // Every result either carries payload or closes a buffer.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_has || r_out_last))
        else $error("empty result");

    // A stop cause is only reported on the last result of a buffer.
    a_cause_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cause != CAUSE_RAN_OUT) |-> (r_out_last && !r_out_has))
        else $error("stop cause on a non-final result");
`endif

endmodule
